@@ rtl/core/fprp_pkg.sv @@
// ============================================================================
// fprp_pkg
// Shared types and constants for the FIFO page frame allocator with pinning.
// ============================================================================
package fprp_pkg;

    // Default sizing
    localparam int FRAMES_DEF   = 256;
    localparam int TAG_BITS_DEF = 16;

    // Fixed field widths of the request and result
    localparam int FRAME_IDX_W = 8;
    localparam int OWNER_W     = 16;

    // Request payload
    typedef struct packed {
        logic               pinned;
        logic [OWNER_W-1:0] owner_tag;
    } t_req;

    // Result payload
    typedef struct packed {
        logic [FRAME_IDX_W-1:0] frame_index;
        logic                   evicted;
        logic [OWNER_W-1:0]     evicted_owner;
        logic                   no_victim;
    } t_rsp;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;    // capture request fields
        logic do_fill;   // hand out the next unused frame
        logic do_none;   // report that every frame is pinned
        logic rd_en;     // read the frame at the victim pointer
        logic step;      // advance the victim pointer past a pinned frame
        logic do_evict;  // reclaim the frame at the victim pointer
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic full;        // every frame has been handed out
        logic all_pinned;  // every frame is pinned
        logic rd_pin;      // pin flag of the frame last read
        logic out_free;    // result register can take a new result
    } t_status;

endpackage

@@ rtl/core/fprp_ctrl.sv @@
// ============================================================================
// fprp_ctrl
// Sequencer: accepts a request, picks fill, no-victim or scan path, and
// walks the victim scan one frame per read/check pair.
// ============================================================================
module fprp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fprp_pkg::t_status  i_status,
    output fprp_pkg::t_cmd     o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FILL  = 5'b00010,
        S_NONE  = 5'b00100,
        S_READ  = 5'b01000,
        S_CHECK = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Decode commands from the current state
    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.do_fill  = (r_state == S_FILL) && i_status.out_free;
        o_cmd.do_none  = (r_state == S_NONE) && i_status.out_free;
        o_cmd.rd_en    = (r_state == S_READ);
        o_cmd.step     = (r_state == S_CHECK) && i_status.rd_pin;
        o_cmd.do_evict = (r_state == S_CHECK) && !i_status.rd_pin && i_status.out_free;
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!i_status.full) begin
                        n_state = S_FILL;
                    end else if (i_status.all_pinned) begin
                        n_state = S_NONE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_FILL: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_NONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_status.rd_pin) begin
                    n_state = S_READ;
                end else if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, clear on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/core/fprp_dp.sv @@
// ============================================================================
// fprp_dp
// Datapath: frame memory (pin flag and owner tag), fill and pin counters,
// victim pointer and the result register.
// ============================================================================
module fprp_dp #(
    parameter int FRAMES   = fprp_pkg::FRAMES_DEF,
    parameter int TAG_BITS = fprp_pkg::TAG_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fprp_pkg::t_cmd     i_cmd,
    input  fprp_pkg::t_req     i_in_data,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output fprp_pkg::t_rsp     o_out_data,
    output fprp_pkg::t_status  o_status
);

    localparam int IDX_W = $clog2(FRAMES);
    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam int FIX_W = fprp_pkg::FRAME_IDX_W;
    localparam int OWN_W = fprp_pkg::OWNER_W;

    // Frame memory: pin flag on top of the owner tag
    logic [TAG_BITS:0]   r_mem [FRAMES];
    logic [TAG_BITS:0]   r_rd_data;

    logic [CNT_W-1:0]    r_fill;
    logic [CNT_W-1:0]    r_pin_cnt;
    logic [IDX_W-1:0]    r_ptr;
    logic [IDX_W-1:0]    n_ptr_inc;
    logic                r_pin;
    logic [TAG_BITS-1:0] r_tag;
    logic                r_out_valid;
    fprp_pkg::t_rsp      r_out;

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [TAG_BITS+OWN_W-1:0] tag_in_ext;
    logic [TAG_BITS+OWN_W-1:0] tag_rd_ext;
    logic [IDX_W+FIX_W-1:0]    fill_ext;
    logic [IDX_W+FIX_W-1:0]    ptr_ext;

    // Fit the request tag to the stored width and back
    assign tag_in_ext = {{TAG_BITS{1'b0}}, i_in_data.owner_tag};
    assign tag_rd_ext = {{OWN_W{1'b0}}, r_rd_data[TAG_BITS-1:0]};
    assign fill_ext   = {{FIX_W{1'b0}}, r_fill[IDX_W-1:0]};
    assign ptr_ext    = {{FIX_W{1'b0}}, r_ptr};

    // Circular advance of the victim pointer
    assign n_ptr_inc = (r_ptr == IDX_W'(FRAMES - 1)) ? '0 : r_ptr + 1'b1;

    assign wr_en   = i_cmd.do_fill || i_cmd.do_evict;
    assign wr_addr = i_cmd.do_fill ? r_fill[IDX_W-1:0] : r_ptr;

    // Capture request fields on transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pin <= i_in_data.pinned;
            r_tag <= tag_in_ext[TAG_BITS-1:0];
        end
    end

    // Write and read the frame memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= {r_pin, r_tag};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_ptr];
        end
    end

    // Advance counters and victim pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_pin_cnt <= '0;
            r_ptr     <= '0;
        end else begin
            if (i_cmd.do_fill) begin
                r_fill <= r_fill + 1'b1;
            end
            if (wr_en) begin
                r_pin_cnt <= r_pin_cnt + CNT_W'(r_pin);
            end
            if (i_cmd.step || i_cmd.do_evict) begin
                r_ptr <= n_ptr_inc;
            end
        end
    end

    // Load the result register, drop it on output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.do_fill || i_cmd.do_none || i_cmd.do_evict) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_fill) begin
            r_out.frame_index   <= fill_ext[FIX_W-1:0];
            r_out.evicted       <= 1'b0;
            r_out.evicted_owner <= '0;
            r_out.no_victim     <= 1'b0;
        end else if (i_cmd.do_evict) begin
            r_out.frame_index   <= ptr_ext[FIX_W-1:0];
            r_out.evicted       <= 1'b1;
            r_out.evicted_owner <= tag_rd_ext[OWN_W-1:0];
            r_out.no_victim     <= 1'b0;
        end else if (i_cmd.do_none) begin
            r_out.frame_index   <= '0;
            r_out.evicted       <= 1'b0;
            r_out.evicted_owner <= '0;
            r_out.no_victim     <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Status back to the sequencer
    assign o_status.full       = (r_fill == CNT_W'(FRAMES));
    assign o_status.all_pinned = (r_pin_cnt == CNT_W'(FRAMES));
    assign o_status.rd_pin     = r_rd_data[TAG_BITS];
    assign o_status.out_free   = !r_out_valid || i_out_ready;

endmodule

@@ rtl/core/fifo_page_replacement_with_pinning.sv @@
// ============================================================================
// fifo_page_replacement_with_pinning
// Page frame allocator: fills unused frames in order, then reclaims the
// first unpinned frame at or after a circular FIFO victim pointer.
// ============================================================================
//
//  Channel  Dir  Handshake                 Payload
//  -------  ---  ------------------------  -------------------------------
//  in       in   i_in_valid / o_in_ready   i_in_data  (pinned, owner_tag)
//  out      out  o_out_valid / i_out_ready o_out_data (frame_index, evicted,
//                                                     evicted_owner, no_victim)
//
//  Fill and all-pinned requests pass from idle through one result state;
//  a reclaim probes 1..FRAMES frames from the victim pointer in turn, as
//  set by the single read port of the frame memory (one probe = read, check).
//  Reset: synchronous, active low; clears state, counts, pointer, out valid.
//  No clearing pass; frame memory is only read after every frame is written.
//  A full result register stalls the final step until it is transferred.
//
module fifo_page_replacement_with_pinning #(
    parameter int FRAMES   = fprp_pkg::FRAMES_DEF,
    parameter int TAG_BITS = fprp_pkg::TAG_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  fprp_pkg::t_req  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output fprp_pkg::t_rsp  o_out_data
);

    fprp_pkg::t_cmd    cmd;
    fprp_pkg::t_status status;

    // Sequencer
    fprp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath
    fprp_dp #(
        .FRAMES   (FRAMES),
        .TAG_BITS (TAG_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_status    (status)
    );

`ifndef SYNTHESIS
    // Block takes one request at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while previous request in progress");

    // No-victim result carries no frame and no eviction
    a_no_victim_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.no_victim) |->
        (!o_out_data.evicted && (o_out_data.frame_index == '0)
         && (o_out_data.evicted_owner == '0)))
        else $error("no-victim result with frame or eviction set");

    // Fill phase never returns once all frames are used
    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.full |=> status.full)
        else $error("fill count dropped below frame count");
`endif

endmodule
